/* rtl/fmbq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmbq_pkg: shared types and constants of the front/middle/back queue
// Command and status codes, and the packed widths of the stream words.
// ----------------------------------------------------------------------------
package fmbq_pkg;

    // stream word widths (fields padded to whole bytes)
    localparam int CMD_W      = 3;
    localparam int FIELD_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_MID   = 3'd1,
        CMD_PUSH_BACK  = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_POP_MID    = 3'd4,
        CMD_POP_BACK   = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

endpackage
`default_nettype wire

/* rtl/fmbq_half_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmbq_half_ram: storage for one half of the queue
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module fmbq_half_ram
    import fmbq_pkg::*;
#(
    parameter int DEPTH  = 512,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 9
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

/* rtl/front_middle_back_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// front_middle_back_queue: bounded queue with front, middle and back access
// Each input word carries a command (push or pop at front, middle or back) and
// a value. Each command returns exactly one output word: the popped value (zero
// for pushes) and a status of ok, pop on empty, or push on full dropped.
// The sequence lives in two RAMs, a front half and a back half, each a
// circular buffer; at most one element moves across per command to keep them balanced.
// Timing: a command is accepted in idle and both halves are read at that edge;
// in the write-back state, once the output register is free or being taken,
// the read data is used, the writes are made and the result word is loaded
// into the output register. The registered read of the half RAMs lies ahead of
// the write-back, so a new command is taken only after the last is written back.
// A result waiting in the output register does not block the next accept;
// the write-back of that next command waits while the receiver stalls.
// Reset clears the state, pointers, counts and output valid; the RAMs need no clearing, so
// the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module front_middle_back_queue
    import fmbq_pkg::*;
#(
    parameter int CAPACITY   = 1024,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // command words
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // [2:0] cmd, [34:3] value, rest zero
    // result words
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata   // [31:0] popped, [33:32] status, rest zero
);

    localparam int HALF_DEPTH = (CAPACITY + 1) / 2;
    localparam int IDX_W      = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
    localparam int CNT_W      = $clog2(HALF_DEPTH + 1);
    localparam int N_W        = $clog2(CAPACITY + 1);

    typedef enum logic {
        ST_IDLE,
        ST_WB
    } state_t;

    // circular index helpers
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                  input logic [IDX_W:0]   off);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + off;
        if (sum >= (IDX_W+1)'(HALF_DEPTH)) begin
            sum = sum - (IDX_W+1)'(HALF_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] base);
        logic [IDX_W-1:0] res;
        if (base == '0) begin
            res = IDX_W'(HALF_DEPTH - 1);
        end else begin
            res = base - 1'b1;
        end
        return res;
    endfunction

    function automatic logic [VALUE_BITS-1:0] to_store(input logic [FIELD_W-1:0] v);
        logic [63:0] w;
        w = {{(64-FIELD_W){v[FIELD_W-1]}}, v};
        return w[VALUE_BITS-1:0];
    endfunction

    function automatic logic [FIELD_W-1:0] to_field(input logic [VALUE_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[FIELD_W-1:0];
    endfunction

    // registers
    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      fstart_reg, fstart_next;
    logic [CNT_W-1:0]      fsize_reg, fsize_next;
    logic [IDX_W-1:0]      bstart_reg, bstart_next;
    logic [CNT_W-1:0]      bsize_reg, bsize_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic                  m_valid_reg, m_valid_next;
    logic [FIELD_W-1:0]    popped_reg, popped_next;
    status_t               status_reg, status_next;

    // RAM ports
    logic                  f_we, b_we, rd_en;
    logic [IDX_W-1:0]      f_waddr, b_waddr, f_raddr, b_raddr;
    logic [VALUE_BITS-1:0] f_wdata, b_wdata, f_rdata, b_rdata;

    // derived indexes and counts
    logic [IDX_W-1:0] f_head_m1, f_tail, f_next, f_inc;
    logic [IDX_W-1:0] b_head_m1, b_tail, b_next, b_inc;
    logic [N_W-1:0]   n_items;
    logic             q_full, q_empty;
    cmd_t             s_cmd;

    assign s_cmd = cmd_t'(s_tdata[CMD_W-1:0]);

    assign f_head_m1 = wrap_dec(fstart_reg);
    assign f_tail    = wrap_add(fstart_reg, (IDX_W+1)'(fsize_reg) - 1'b1);
    assign f_next    = wrap_add(fstart_reg, (IDX_W+1)'(fsize_reg));
    assign f_inc     = wrap_add(fstart_reg, (IDX_W+1)'(1));
    assign b_head_m1 = wrap_dec(bstart_reg);
    assign b_tail    = wrap_add(bstart_reg, (IDX_W+1)'(bsize_reg) - 1'b1);
    assign b_next    = wrap_add(bstart_reg, (IDX_W+1)'(bsize_reg));
    assign b_inc     = wrap_add(bstart_reg, (IDX_W+1)'(1));

    assign n_items = N_W'(fsize_reg) + N_W'(bsize_reg);
    assign q_full  = (n_items >= N_W'(CAPACITY));
    assign q_empty = (n_items == '0);

    // read addresses follow the incoming command
    assign f_raddr = (s_cmd == CMD_POP_FRONT) ? fstart_reg : f_tail;
    assign b_raddr = (s_cmd == CMD_POP_BACK)  ? b_tail     : bstart_reg;

    fmbq_half_ram #(
        .DEPTH  (HALF_DEPTH),
        .WIDTH  (VALUE_BITS),
        .ADDR_W (IDX_W)
    ) u_front (
        .aclk  (aclk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .re    (rd_en),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    fmbq_half_ram #(
        .DEPTH  (HALF_DEPTH),
        .WIDTH  (VALUE_BITS),
        .ADDR_W (IDX_W)
    ) u_back (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .re    (rd_en),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    // command sequencing and read-modify-write
    always_comb begin
        state_next   = state_reg;
        fstart_next  = fstart_reg;
        fsize_next   = fsize_reg;
        bstart_next  = bstart_reg;
        bsize_next   = bsize_reg;
        cmd_next     = cmd_reg;
        value_next   = value_reg;
        m_valid_next = m_valid_reg;
        popped_next  = popped_reg;
        status_next  = status_reg;
        rd_en        = 1'b0;
        f_we         = 1'b0;
        f_waddr      = f_next;
        f_wdata      = value_reg;
        b_we         = 1'b0;
        b_waddr      = b_next;
        b_wdata      = value_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    rd_en      = 1'b1;
                    cmd_next   = s_cmd;
                    value_next = to_store(s_tdata[CMD_W +: FIELD_W]);
                    state_next = ST_WB;
                end
            end
            ST_WB: begin
                if (!m_valid_reg || m_tready) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                    popped_next  = '0;
                    status_next  = STAT_OK;
                    unique case (cmd_reg)
                        CMD_PUSH_FRONT: begin
                            if (q_full) begin
                                status_next = STAT_FULL;
                            end else begin
                                // front tail moves to back head when front is long
                                if (fsize_reg > bsize_reg) begin
                                    b_we        = 1'b1;
                                    b_waddr     = b_head_m1;
                                    b_wdata     = f_rdata;
                                    bstart_next = b_head_m1;
                                    bsize_next  = bsize_reg + 1'b1;
                                end else begin
                                    fsize_next  = fsize_reg + 1'b1;
                                end
                                f_we        = 1'b1;
                                f_waddr     = f_head_m1;
                                fstart_next = f_head_m1;
                            end
                        end
                        CMD_PUSH_MID: begin
                            if (q_full) begin
                                status_next = STAT_FULL;
                            end else if (fsize_reg > bsize_reg) begin
                                // old tail to the back, new value takes its slot
                                b_we        = 1'b1;
                                b_waddr     = b_head_m1;
                                b_wdata     = f_rdata;
                                bstart_next = b_head_m1;
                                bsize_next  = bsize_reg + 1'b1;
                                f_we        = 1'b1;
                                f_waddr     = f_tail;
                            end else begin
                                f_we        = 1'b1;
                                fsize_next  = fsize_reg + 1'b1;
                            end
                        end
                        CMD_PUSH_BACK: begin
                            if (q_full) begin
                                status_next = STAT_FULL;
                            end else begin
                                b_we = 1'b1;
                                if (bsize_reg >= fsize_reg) begin
                                    // back head moves over; an empty back hands on the new word
                                    f_we        = 1'b1;
                                    f_wdata     = (bsize_reg == '0) ? value_reg : b_rdata;
                                    fsize_next  = fsize_reg + 1'b1;
                                    bstart_next = b_inc;
                                end else begin
                                    bsize_next  = bsize_reg + 1'b1;
                                end
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (q_empty) begin
                                status_next = STAT_EMPTY;
                            end else begin
                                popped_next = to_field(f_rdata);
                                fstart_next = f_inc;
                                if (bsize_reg >= fsize_reg) begin
                                    f_we        = 1'b1;
                                    f_wdata     = b_rdata;
                                    bstart_next = b_inc;
                                    bsize_next  = bsize_reg - 1'b1;
                                end else begin
                                    fsize_next  = fsize_reg - 1'b1;
                                end
                            end
                        end
                        CMD_POP_MID: begin
                            if (q_empty) begin
                                status_next = STAT_EMPTY;
                            end else begin
                                popped_next = to_field(f_rdata);
                                if (bsize_reg >= fsize_reg) begin
                                    // back head refills the freed tail slot
                                    f_we        = 1'b1;
                                    f_waddr     = f_tail;
                                    f_wdata     = b_rdata;
                                    bstart_next = b_inc;
                                    bsize_next  = bsize_reg - 1'b1;
                                end else begin
                                    fsize_next  = fsize_reg - 1'b1;
                                end
                            end
                        end
                        CMD_POP_BACK: begin
                            if (q_empty) begin
                                status_next = STAT_EMPTY;
                            end else if (bsize_reg == '0) begin
                                // single item, held in the front half
                                popped_next = to_field(f_rdata);
                                fsize_next  = fsize_reg - 1'b1;
                            end else begin
                                popped_next = to_field(b_rdata);
                                if (fsize_reg > bsize_reg) begin
                                    b_we        = 1'b1;
                                    b_waddr     = b_head_m1;
                                    b_wdata     = f_rdata;
                                    bstart_next = b_head_m1;
                                    fsize_next  = fsize_reg - 1'b1;
                                end else begin
                                    bsize_next  = bsize_reg - 1'b1;
                                end
                            end
                        end
                        default: begin
                            // unused codes: no change, ok status
                            status_next = STAT_OK;
                        end
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state, pointers and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fstart_reg  <= '0;
            fsize_reg   <= '0;
            bstart_reg  <= '0;
            bsize_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fstart_reg  <= fstart_next;
            fsize_reg   <= fsize_next;
            bstart_reg  <= bstart_next;
            bsize_reg   <= bsize_next;
            m_valid_reg <= m_valid_next;
        end
        cmd_reg    <= cmd_next;
        value_reg  <= value_next;
        popped_reg <= popped_next;
        status_reg <= status_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_TDATA_W - FIELD_W - STATUS_W)'(0), status_reg, popped_reg};

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the front/middle/back queue
// Streams command words into the block and checks every result word against
// a behavioural model of the queue, which is kept as one ordered list. Both
// stream sides idle at random. The run covers empty pops, unused commands,
// fill to capacity with dropped pushes, a pop-heavy tail, and mixed traffic.
// ----------------------------------------------------------------------------
module tb_top;
    import fmbq_pkg::*;

    localparam int QUEUE_CAPACITY = 1024;
    localparam int MAX_REPORTS    = 10;

    // command codes with no function; the block must answer them as no-ops
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [FIELD_W-1:0] value;
    } cmd_word_t;

    typedef struct packed {
        logic [FIELD_W-1:0] popped;
        status_t            status;
    } queue_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;    // [2:0] cmd, [34:3] value, rest zero
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // [31:0] popped, [33:32] status, rest zero

    cmd_word_t          cmd_backlog[$];     // words not yet offered to the block
    queue_result_t      results_owed[$];    // predicted results in order
    logic [FIELD_W-1:0] held_values[$];     // model contents, front first
    int                 fill_level = 0;     // occupancy as seen by the generator
    int                 fail_count = 0;

    int burst_left = 0;
    int gap_left   = 0;
    int stall_mode = 0;
    int stall_left = 0;
    int stall_tick = 0;

    front_middle_back_queue #(
        .CAPACITY   (QUEUE_CAPACITY),
        .VALUE_BITS (FIELD_W)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    // behavioural queue: middle push at n/2, middle pop at (n-1)/2
    function automatic queue_result_t apply_command(cmd_word_t w);
        queue_result_t r;
        int            n;
        r.popped = '0;
        r.status = STAT_OK;
        n        = held_values.size();
        case (w.cmd)
            CMD_PUSH_FRONT, CMD_PUSH_MID, CMD_PUSH_BACK: begin
                if (n >= QUEUE_CAPACITY) begin
                    r.status = STAT_FULL;
                end else if (w.cmd == CMD_PUSH_FRONT) begin
                    held_values.insert(0, w.value);
                end else if (w.cmd == CMD_PUSH_MID) begin
                    held_values.insert(n / 2, w.value);
                end else begin
                    held_values.insert(n, w.value);
                end
            end
            CMD_POP_FRONT, CMD_POP_MID, CMD_POP_BACK: begin
                if (n == 0) begin
                    r.status = STAT_EMPTY;
                end else if (w.cmd == CMD_POP_FRONT) begin
                    r.popped = held_values[0];
                    held_values.delete(0);
                end else if (w.cmd == CMD_POP_MID) begin
                    r.popped = held_values[(n - 1) / 2];
                    held_values.delete((n - 1) / 2);
                end else begin
                    r.popped = held_values[n - 1];
                    held_values.delete(n - 1);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic note_failure(string what, logic [FIELD_W-1:0] want,
                                logic [FIELD_W-1:0] got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
    endtask

    task automatic add_word(logic [CMD_W-1:0] c, logic [FIELD_W-1:0] v);
        cmd_word_t w;
        w.cmd   = c;
        w.value = v;
        cmd_backlog.insert(cmd_backlog.size(), w);
        if (c <= CMD_PUSH_BACK && fill_level < QUEUE_CAPACITY)
            fill_level++;
        else if (c >= CMD_POP_FRONT && c <= CMD_POP_BACK && fill_level > 0)
            fill_level--;
    endtask

    // one random word; push_pct weights pushes against pops
    task automatic add_random_word(int push_pct);
        logic [CMD_W-1:0]   c;
        logic [FIELD_W-1:0] v;
        if ($urandom_range(99) < 2)
            c = $urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO;
        else if ($urandom_range(99) < push_pct)
            c = CMD_W'(CMD_PUSH_FRONT + $urandom_range(2));
        else
            c = CMD_W'(CMD_POP_FRONT + $urandom_range(2));
        case ($urandom_range(15))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7fff_ffff;
            2:       v = 32'hffff_ffff;
            3:       v = 32'h0000_0000;
            default: v = $urandom;
        endcase
        add_word(c, v);
    endtask

    // sender: bursts of words with random gaps between them
    always @(posedge aclk) begin
        cmd_word_t w;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (cmd_backlog.size() > 0) begin
                w = cmd_backlog[0];
                cmd_backlog.delete(0);
                s_tvalid <= 1'b1;
                s_tdata  <= {{(S_TDATA_W - CMD_W - FIELD_W){1'b0}}, w.value, w.cmd};
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stall modes chosen at random, each kept for a random span
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            stall_tick <= stall_tick + 1;
            if (stall_left == 0) begin
                stall_mode <= $urandom_range(3);
                stall_left <= $urandom_range(20, 300);
            end else begin
                stall_left <= stall_left - 1;
            end
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(3) != 0);
                2:       m_tready <= ($urandom_range(3) == 0);
                default: m_tready <= ((stall_tick % 7) < 3);
            endcase
        end
    end

    // monitor: check the result word first, then predict the accepted command
    always @(posedge aclk) begin
        queue_result_t got;
        queue_result_t want;
        cmd_word_t     w;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.popped = m_tdata[FIELD_W-1:0];
                got.status = status_t'(m_tdata[FIELD_W +: STATUS_W]);
                if (results_owed.size() == 0) begin
                    note_failure("unexpected result", '0, m_tdata[FIELD_W-1:0]);
                end else begin
                    want = results_owed[0];
                    results_owed.delete(0);
                    if (got.popped !== want.popped)
                        note_failure("popped", want.popped, got.popped);
                    if (got.status !== want.status)
                        note_failure("status", FIELD_W'(want.status), FIELD_W'(got.status));
                end
            end
            if (s_tvalid && s_tready) begin
                w.cmd   = s_tdata[CMD_W-1:0];
                w.value = s_tdata[CMD_W +: FIELD_W];
                results_owed.insert(results_owed.size(), apply_command(w));
            end
        end
    end

    // stimulus and end of run
    initial begin
        // directed: empty pops, spare codes, single-item back pop, extremes
        add_word(CMD_POP_FRONT, 32'h1111_1111);
        add_word(CMD_POP_MID, 32'h2222_2222);
        add_word(CMD_POP_BACK, 32'h3333_3333);
        add_word(CMD_SPARE_LO, 32'hffff_ffff);
        add_word(CMD_SPARE_HI, 32'h0000_0000);
        add_word(CMD_PUSH_BACK, 32'h7fff_ffff);
        add_word(CMD_POP_BACK, 32'h0000_0000);
        add_word(CMD_PUSH_FRONT, 32'h8000_0000);
        add_word(CMD_PUSH_MID, 32'h0000_0000);
        add_word(CMD_PUSH_BACK, 32'hffff_ffff);
        add_word(CMD_PUSH_MID, 32'h1234_5678);
        add_word(CMD_PUSH_FRONT, 32'h0000_0001);
        add_word(CMD_SPARE_LO, 32'h5555_5555);
        add_word(CMD_POP_MID, 32'h0);
        add_word(CMD_POP_MID, 32'h0);
        add_word(CMD_POP_BACK, 32'h0);
        add_word(CMD_PUSH_MID, 32'ha5a5_a5a5);
        add_word(CMD_POP_FRONT, 32'h0);
        add_word(CMD_POP_BACK, 32'h0);
        add_word(CMD_POP_MID, 32'h0);
        add_word(CMD_POP_FRONT, 32'h0);
        add_word(CMD_POP_MID, 32'h0);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // hold off until the directed words have all been answered
        while (cmd_backlog.size() > 0 || s_tvalid || results_owed.size() > 0)
            @(posedge aclk);

        // mixed traffic around low occupancy
        repeat (100) add_random_word(55);
        // fill to capacity, then keep pushing into a full queue
        while (fill_level < QUEUE_CAPACITY) add_random_word(95);
        repeat (40) add_random_word(80);
        // pop-heavy traffic to finish
        repeat (180) add_random_word(10);

        while (cmd_backlog.size() > 0 || s_tvalid || results_owed.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
